>>> sv/mspi_pkg.sv
`timescale 1ns / 1ps

package mspi_pkg;

  localparam int RingDepth = 16;
  localparam int FracBits  = 8;

  localparam int PeriodW = 16;
  localparam int TrimW   = 10;
  localparam int RefW    = 8;
  localparam int GainW   = 16;
  localparam int DutyW   = 8;
  localparam int SpeedW  = 12;

  localparam int IdxW = $clog2(RingDepth);
  localparam int SumW = PeriodW + $clog2(RingDepth);

  // speed numerator and quotient width
  localparam int SpeedNum = RingDepth * 78125;
  localparam int NumW     = $clog2(SpeedNum + 1);
  localparam int SpeedMax = 4095;

  // trim offset by reciprocal multiply, exact for magnitudes up to the centre
  localparam int TrimCenter = 512;
  localparam int TrimDiv    = 51;
  localparam int TrimShift  = 16;
  localparam int TrimRecip  = ((1 << TrimShift) + TrimDiv - 1) / TrimDiv;
  localparam int TrimMagW   = TrimW + 1;
  localparam int TrimProdW  = TrimMagW + $clog2(TrimRecip + 1);
  localparam int OffW       = 5;

  localparam int ErrW  = 14;
  localparam int AccW  = 32;
  localparam int McW   = AccW + 1;
  localparam int ProdW = McW + GainW;

  localparam int DutyMax = 255;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegRefSpeed  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainP     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainI     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStepTime  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinPeriod = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxPeriod = 3'd5;

  localparam logic [GainW-1:0]   GainPReset    = 16'd256;
  localparam logic [GainW-1:0]   GainIReset    = 16'd512;
  localparam logic [GainW-1:0]   StepTimeReset = 16'd80;
  localparam logic [PeriodW-1:0] MinPerReset   = 16'd370;
  localparam logic [PeriodW-1:0] MaxPerReset   = 16'd15725;

  typedef struct packed {
    logic                    start;
    logic signed [McW-1:0]   mcand;
    logic        [GainW-1:0] mplier;
  } mul_req_t;

endpackage

>>> sv/motor_speed_pi_controller_core.sv
`timescale 1ns / 1ps

// Motor speed PI controller with encoder period ring.
// Requests enter on the s_axis channel: tuser 0 is an encoder edge carrying a
// period count, tuser 1 is a control tick carrying a trim sample. Every request
// gives exactly one response on m_axis: current duty, current speed and a flag
// in tuser set when the duty was recomputed.
// Registers are written through the cfg channel (index 0 ref_speed, 1 gain_p,
// 2 gain_i, 3 step_time, 4 min_period, 5 max_period, others ignored); it is
// always ready and should be used only while the block is idle.
// An edge request passes through the edge step and then the output step. A
// control tick runs the bit-serial speed division, three passes through the
// shared bit-serial multiplier and the steps for operand loading, handover,
// saturation and clamping. One request is in flight at a time, so a new
// request is taken only when the previous one has left the working steps.
// The response sits in an output register; the next request is accepted as
// soon as the previous one has been moved there, and a stalled receiver holds
// the block only when a second response is ready to be stored.
// Reset (rst_ni low, asynchronous) clears the period ring, sum, integral,
// duty and speed, and loads the default register values.
module motor_speed_pi_controller_core
  import mspi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // period_count, trim_sample
  input  logic                s_axis_tuser,  // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // duty, speed
  output logic                m_axis_tuser,  // duty_updated
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_DIV,
    ST_ERR,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_G,
    ST_FINAL,
    ST_OUT
  } state_e;

  state_e                 state_q;

  logic [RefW-1:0]        ref_speed_q;
  logic [GainW-1:0]       gain_p_q;
  logic [GainW-1:0]       gain_i_q;
  logic [GainW-1:0]       step_time_q;
  logic [PeriodW-1:0]     min_period_q;
  logic [PeriodW-1:0]     max_period_q;

  logic                   func_q;
  logic [PeriodW-1:0]     period_q;
  logic [TrimW-1:0]       trim_q;

  logic [PeriodW-1:0]     ring_q [RingDepth];
  logic [IdxW-1:0]        idx_q;
  logic [SumW-1:0]        sum_q;
  logic signed [AccW-1:0] integral_q;
  logic [DutyW-1:0]       duty_q;
  logic [SpeedW-1:0]      speed_q;
  logic signed [ErrW-1:0] err_q;
  logic signed [ProdW-1:0] t_prop_q;
  logic signed [ProdW-1:0] t_int_q;

  logic                   div_start_q;
  mul_req_t               mul_req_q;

  logic                   m_valid_q;
  logic [DutyW-1:0]       out_duty_q;
  logic [SpeedW-1:0]      out_speed_q;
  logic                   out_upd_q;

  logic                   div_done;
  logic [NumW-1:0]        quotient;
  logic                   mul_done;
  logic signed [ProdW-1:0] mul_prod;

  logic                   in_fire;
  logic                   period_ok;

  logic signed [TrimW:0]   trim_diff;
  logic [TrimMagW-1:0]     trim_mag;
  logic [TrimProdW-1:0]    trim_prod;
  logic [OffW-2:0]         trim_quo;
  logic signed [OffW-1:0]  trim_off;
  logic signed [ErrW-1:0]  err_next;

  logic [SpeedW-1:0]       speed_next;
  logic signed [ProdW:0]   int_sum;
  logic signed [AccW-1:0]  int_sat;
  logic signed [ProdW-1:0] rnd;
  logic signed [ProdW:0]   pwm_sum;
  logic signed [ProdW:0]   pwm_sh;
  logic [DutyW-1:0]        duty_next;

  mspi_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .divisor_i  (sum_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  mspi_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req_q),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign period_ok = (period_q > min_period_q) && (period_q < max_period_q);

  // trim offset, truncated toward zero
  assign trim_diff = $signed({1'b0, trim_q}) - $signed((TrimW + 1)'(TrimCenter));
  assign trim_mag  = trim_diff[TrimW] ? TrimMagW'(-trim_diff) : TrimMagW'(trim_diff);
  assign trim_prod = TrimProdW'(trim_mag) * TrimProdW'(TrimRecip);
  assign trim_quo  = trim_prod[TrimShift +: (OffW - 1)];
  assign trim_off  = trim_diff[TrimW] ? -$signed({1'b0, trim_quo}) : $signed({1'b0, trim_quo});

  assign err_next = $signed({{(ErrW - RefW){1'b0}}, ref_speed_q})
                  + $signed({{(ErrW - OffW){trim_off[OffW-1]}}, trim_off})
                  - $signed({{(ErrW - SpeedW){1'b0}}, speed_q});

  always_comb begin
    if (sum_q == '0) begin
      speed_next = '0;
    end else if (quotient > NumW'(SpeedMax)) begin
      speed_next = SpeedW'(SpeedMax);
    end else begin
      speed_next = quotient[SpeedW-1:0];
    end
  end

  // integral update with saturation at the 32-bit limits
  assign int_sum = $signed({{(ProdW + 1 - AccW){integral_q[AccW-1]}}, integral_q})
                 + $signed({mul_prod[ProdW-1], mul_prod});

  always_comb begin
    if ((&int_sum[ProdW:AccW-1]) || !(|int_sum[ProdW:AccW-1])) begin
      int_sat = int_sum[AccW-1:0];
    end else if (int_sum[ProdW]) begin
      int_sat = {1'b1, {(AccW - 1){1'b0}}};
    end else begin
      int_sat = {1'b0, {(AccW - 1){1'b1}}};
    end
  end

  assign rnd = mul_prod + $signed(ProdW'(1 << (FracBits - 1)));

  assign pwm_sum = $signed({t_prop_q[ProdW-1], t_prop_q})
                 + $signed({t_int_q[ProdW-1], t_int_q});
  assign pwm_sh  = pwm_sum >>> FracBits;

  always_comb begin
    if (pwm_sh[ProdW]) begin
      duty_next = '0;
    end else if (|pwm_sh[ProdW-1:DutyW]) begin
      duty_next = DutyW'(DutyMax);
    end else begin
      duty_next = pwm_sh[DutyW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_speed_q  <= '0;
      gain_p_q     <= GainPReset;
      gain_i_q     <= GainIReset;
      step_time_q  <= StepTimeReset;
      min_period_q <= MinPerReset;
      max_period_q <= MaxPerReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegRefSpeed:  ref_speed_q  <= cfg_data_i[RefW-1:0];
        RegGainP:     gain_p_q     <= cfg_data_i[GainW-1:0];
        RegGainI:     gain_i_q     <= cfg_data_i[GainW-1:0];
        RegStepTime:  step_time_q  <= cfg_data_i[GainW-1:0];
        RegMinPeriod: min_period_q <= cfg_data_i[PeriodW-1:0];
        RegMaxPeriod: max_period_q <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= 1'b0;
      period_q    <= '0;
      trim_q      <= '0;
      for (int i = 0; i < RingDepth; i++) begin
        ring_q[i] <= '0;
      end
      idx_q       <= '0;
      sum_q       <= '0;
      integral_q  <= '0;
      duty_q      <= '0;
      speed_q     <= '0;
      err_q       <= '0;
      t_prop_q    <= '0;
      t_int_q     <= '0;
      div_start_q <= 1'b0;
      mul_req_q   <= '0;
      m_valid_q   <= 1'b0;
      out_duty_q  <= '0;
      out_speed_q <= '0;
      out_upd_q   <= 1'b0;
    end else begin
      div_start_q     <= 1'b0;
      mul_req_q.start <= 1'b0;
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            func_q   <= s_axis_tuser;
            period_q <= s_axis_tdata[PeriodW-1:0];
            trim_q   <= s_axis_tdata[PeriodW +: TrimW];
            if (s_axis_tuser) begin
              div_start_q <= 1'b1;
              state_q     <= ST_DIV;
            end else begin
              state_q <= ST_EDGE;
            end
          end
        end
        ST_EDGE: begin
          if (period_ok) begin
            sum_q         <= sum_q - SumW'(ring_q[idx_q]) + SumW'(period_q);
            ring_q[idx_q] <= period_q;
            idx_q         <= (idx_q == IdxW'(RingDepth - 1)) ? '0 : idx_q + 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_DIV: begin
          if (div_done) begin
            speed_q <= speed_next;
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_q            <= err_next;
          mul_req_q.start  <= 1'b1;
          mul_req_q.mcand  <= McW'(err_next);
          mul_req_q.mplier <= step_time_q;
          state_q          <= ST_MUL_I;
        end
        ST_MUL_I: begin
          if (mul_done) begin
            integral_q       <= int_sat;
            mul_req_q.start  <= 1'b1;
            mul_req_q.mcand  <= McW'(err_q);
            mul_req_q.mplier <= gain_p_q;
            state_q          <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          if (mul_done) begin
            t_prop_q         <= mul_prod;
            mul_req_q.start  <= 1'b1;
            mul_req_q.mcand  <= McW'(integral_q);
            mul_req_q.mplier <= gain_i_q;
            state_q          <= ST_MUL_G;
          end
        end
        ST_MUL_G: begin
          if (mul_done) begin
            t_int_q <= rnd >>> FracBits;
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          duty_q  <= duty_next;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q   <= 1'b1;
            out_duty_q  <= duty_q;
            out_speed_q <= speed_q;
            out_upd_q   <= func_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(24 - DutyW - SpeedW)'(0), out_speed_q, out_duty_q};
  assign m_axis_tuser  = out_upd_q;

`ifndef ASSERT_OFF
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL_I || state_q == ST_MUL_P || state_q == ST_MUL_G))
    else $error("multiplier finished outside a multiply step");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the speed step");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("request accepted but controller stayed idle");

  a_resp_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_OUT))
    else $error("response raised outside the output step");
`endif

endmodule

>>> sv/mspi_serial_mul.sv
`timescale 1ns / 1ps

module mspi_serial_mul
  import mspi_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mul_req_t                req_i,
  output logic                    done_o,
  output logic signed [ProdW-1:0] product_o
);

  localparam int CntW = $clog2(GainW);

  logic                    busy_q;
  logic                    done_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [McW-1:0]   mc_q;
  logic [GainW-1:0]        mpl_q;
  logic signed [McW-1:0]   hi_q;
  logic [GainW-1:0]        lo_q;
  logic signed [McW:0]     addend;
  logic signed [McW:0]     sum;

  // one multiplier bit per cycle, lsb first, partial product shifted right
  assign addend = mpl_q[0] ? $signed({mc_q[McW-1], mc_q}) : '0;
  assign sum    = $signed({hi_q[McW-1], hi_q}) + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mc_q   <= '0;
      mpl_q  <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        mc_q   <= req_i.mcand;
        mpl_q  <= req_i.mplier;
        hi_q   <= '0;
        lo_q   <= '0;
      end else if (busy_q) begin
        hi_q  <= sum[McW:1];
        lo_q  <= {sum[0], lo_q[GainW-1:1]};
        mpl_q <= {1'b0, mpl_q[GainW-1:1]};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(GainW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

>>> sv/mspi_serial_div.sv
`timescale 1ns / 1ps

module mspi_serial_div
  import mspi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quotient_o
);

  localparam int CntW = $clog2(NumW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] div_q;
  logic [SumW-1:0] rem_q;
  logic [NumW-1:0] num_q;
  logic [SumW:0]   rem_shift;
  logic [SumW:0]   diff;
  logic            ge;

  // restoring division, numerator bits leave at the top, quotient bits enter below
  assign rem_shift = {rem_q, num_q[NumW-1]};
  assign ge        = rem_shift >= {1'b0, div_q};
  assign diff      = rem_shift - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      num_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        div_q  <= divisor_i;
        rem_q  <= '0;
        num_q  <= NumW'(SpeedNum);
      end else if (busy_q) begin
        rem_q <= ge ? diff[SumW-1:0] : rem_shift[SumW-1:0];
        num_q <= {num_q[NumW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

>>> verif/tb_motor_speed_pi_controller_core.sv
`timescale 1ns / 1ps

module tb_motor_speed_pi_controller_core;
  import mspi_pkg::*;

  localparam bit FuncEdge = 1'b0;
  localparam bit FuncTick = 1'b1;

  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  localparam longint AccHi = 2147483647;
  localparam longint AccLo = -longint'(2147483647) - 1;

  typedef struct packed {
    logic [DutyW-1:0]  duty;
    logic [SpeedW-1:0] speed;
    logic              upd;
  } resp_t;

  typedef struct packed {
    logic                wr;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    logic                kind;
    logic [PeriodW-1:0]  per;
    logic [TrimW-1:0]    trim;
    logic                known;
    logic [DutyW-1:0]    duty;
    logic [SpeedW-1:0]   speed;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;  // period_count, trim_sample
  logic                s_axis_tuser  = 1'b0;  // func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;  // duty, speed
  logic                m_axis_tuser;  // duty_updated
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // shadow of the block's registers and state
  logic [RefW-1:0]    set_ref = '0;
  logic [GainW-1:0]   set_kp  = GainPReset;
  logic [GainW-1:0]   set_ki  = GainIReset;
  logic [GainW-1:0]   set_dt  = StepTimeReset;
  logic [PeriodW-1:0] lim_lo  = MinPerReset;
  logic [PeriodW-1:0] lim_hi  = MaxPerReset;

  logic [PeriodW-1:0] hist [RingDepth] = '{default: '0};
  logic [IdxW-1:0]    hist_ptr  = '0;
  logic [SumW-1:0]    hist_sum  = '0;
  int                 integ     = 0;
  logic [DutyW-1:0]   duty_now  = '0;
  logic [SpeedW-1:0]  speed_now = '0;

  resp_t    duty_speed_q [$];
  dir_row_t dir_tab [$];

  int n_err        = 0;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int rx_hold_len  = 0;

  motor_speed_pi_controller_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint qround(longint a, longint b);
    return (a * b + (longint'(1) << (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic resp_t pi_update(bit kind, logic [PeriodW-1:0] per,
                                      logic [TrimW-1:0] trim);
    resp_t  r;
    int     ofs;
    longint err;
    longint acc;
    longint pwm;
    if (kind == FuncEdge) begin
      if (per > lim_lo && per < lim_hi) begin
        hist_sum = hist_sum - SumW'(hist[hist_ptr]) + SumW'(per);
        hist[hist_ptr] = per;
        hist_ptr = hist_ptr + 1'b1;
      end
    end else begin
      ofs = (int'(trim) - TrimCenter) / TrimDiv;
      if (hist_sum == '0) begin
        speed_now = '0;
      end else if (SpeedNum / hist_sum > SpeedMax) begin
        speed_now = SpeedW'(SpeedMax);
      end else begin
        speed_now = SpeedW'(SpeedNum / hist_sum);
      end
      err = (longint'(set_ref) + ofs - longint'(speed_now)) * (longint'(1) << FracBits);
      acc = longint'(integ) + qround(err, longint'(set_dt));
      if (acc > AccHi) begin
        acc = AccHi;
      end else if (acc < AccLo) begin
        acc = AccLo;
      end
      integ = int'(acc);
      pwm = (qround(longint'(set_kp), err) + qround(longint'(set_ki), acc)) >>> FracBits;
      if (pwm > DutyMax) begin
        duty_now = DutyW'(DutyMax);
      end else if (pwm < 0) begin
        duty_now = '0;
      end else begin
        duty_now = DutyW'(pwm);
      end
    end
    r.duty  = duty_now;
    r.speed = speed_now;
    r.upd   = (kind == FuncTick);
    return r;
  endfunction

  function automatic dir_row_t row_wr(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    dir_row_t d = '0;
    d.wr  = 1'b1;
    d.idx = idx;
    d.val = val;
    return d;
  endfunction

  function automatic dir_row_t row_req(bit kind, logic [PeriodW-1:0] per,
                                       logic [TrimW-1:0] trim);
    dir_row_t d = '0;
    d.kind = kind;
    d.per  = per;
    d.trim = trim;
    return d;
  endfunction

  function automatic dir_row_t row_known(bit kind, logic [PeriodW-1:0] per,
                                         logic [TrimW-1:0] trim, logic [DutyW-1:0] duty,
                                         logic [SpeedW-1:0] speed);
    dir_row_t d = row_req(kind, per, trim);
    d.known = 1'b1;
    d.duty  = duty;
    d.speed = speed;
    return d;
  endfunction

  function automatic logic [GainW-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return GainW'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegRefSpeed:  set_ref = val[RefW-1:0];
      RegGainP:     set_kp  = val;
      RegGainI:     set_ki  = val;
      RegStepTime:  set_dt  = val;
      RegMinPeriod: lim_lo  = val;
      RegMaxPeriod: lim_hi  = val;
      default: ;
    endcase
  endtask

  task automatic send_req(bit kind, logic [PeriodW-1:0] per, logic [TrimW-1:0] trim,
                          bit known, logic [DutyW-1:0] kduty, logic [SpeedW-1:0] kspeed);
    resp_t r;
    while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, trim, per};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = pi_update(kind, per, trim);
    if (known) begin
      r.duty  = kduty;
      r.speed = kspeed;
    end
    duty_speed_q.push_back(r);
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (duty_speed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(int n_items, int gap, int stall, bit windup);
    int                 lo;
    int                 hi;
    bit                 kind;
    logic [PeriodW-1:0] per;
    logic [TrimW-1:0]   trim;
    drain_all();
    tx_gap_pct   = gap;
    rx_stall_pct = stall;
    if (windup) begin
      lo = 0;
      hi = 65535;
      write_reg(RegRefSpeed, 16'd255);
      write_reg(RegStepTime, 16'hFFFF);
      write_reg(RegGainP, rand_gain());
      write_reg(RegGainI, rand_gain());
    end else begin
      case ($urandom_range(0, 5))
        0: begin lo = 0; hi = 40; end
        1: begin lo = $urandom_range(0, 65535); hi = $urandom_range(0, lo); end
        2: begin lo = 0; hi = 65535; end
        default: begin lo = $urandom_range(0, 3000); hi = lo + $urandom_range(2, 20000); end
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(RegRefSpeed, 16'd0);
        1: write_reg(RegRefSpeed, 16'd255);
        default: write_reg(RegRefSpeed, 16'($urandom_range(0, 255)));
      endcase
      write_reg(RegGainP, rand_gain());
      write_reg(RegGainI, rand_gain());
      write_reg(RegStepTime, rand_gain());
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? RegSpareA : RegSpareB, 16'($urandom));
      end
    end
    write_reg(RegMinPeriod, 16'(lo));
    write_reg(RegMaxPeriod, 16'(hi));
    cfg_valid_i <= 1'b0;

    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 3 && gap == 0) begin
        rx_hold_len = 300;
      end
      if (i == n_items / 2) begin
        drain_all();
      end
      if (windup) begin
        kind = (i >= RingDepth) && ($urandom_range(9) != 0);
        per  = PeriodW'($urandom_range(60000, 65534));
        trim = TrimW'($urandom_range(900, 1023));
      end else begin
        kind = ($urandom_range(99) < 35);
        if (hi > lo + 1 && $urandom_range(9) < 8) begin
          per = PeriodW'($urandom_range(lo + 1, hi - 1));
        end else begin
          per = PeriodW'($urandom);
        end
        trim = TrimW'($urandom_range(0, 1023));
      end
      send_req(kind, per, trim, 1'b0, '0, '0);
    end
  endtask

  // response side: checks and back-pressure
  initial begin
    resp_t exp_r;
    int    hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (duty_speed_q.size() == 0) begin
          $display("%0t: response with none expected: duty %0d speed %0d updated %0b",
                   $time, m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tuser);
          n_err++;
        end else begin
          exp_r = duty_speed_q.pop_front();
          if (m_axis_tdata[7:0] !== exp_r.duty) begin
            $display("%0t: duty expected %0d actual %0d", $time, exp_r.duty,
                     m_axis_tdata[7:0]);
            n_err++;
          end
          if (m_axis_tdata[19:8] !== exp_r.speed) begin
            $display("%0t: speed expected %0d actual %0d", $time, exp_r.speed,
                     m_axis_tdata[19:8]);
            n_err++;
          end
          if (m_axis_tuser !== exp_r.upd) begin
            $display("%0t: duty_updated expected %0b actual %0b", $time, exp_r.upd,
                     m_axis_tuser);
            n_err++;
          end
        end
      end
      if (rx_hold_len != 0) begin
        hold_left   = rx_hold_len;
        rx_hold_len = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    bit prev_wr;
    prev_wr = 1'b0;

    // empty ring, limits at their edges, trim extremes and rounding
    dir_tab.push_back(row_known(FuncTick, '0, 10'd512, 8'd0, 12'd0));
    dir_tab.push_back(row_known(FuncEdge, 16'd0, '0, 8'd0, 12'd0));
    dir_tab.push_back(row_known(FuncEdge, 16'hFFFF, '0, 8'd0, 12'd0));
    dir_tab.push_back(row_known(FuncEdge, 16'd370, '0, 8'd0, 12'd0));
    dir_tab.push_back(row_known(FuncEdge, 16'd15725, '0, 8'd0, 12'd0));
    dir_tab.push_back(row_known(FuncTick, '0, 10'd0, 8'd0, 12'd0));
    dir_tab.push_back(row_req(FuncTick, '0, 10'd1023));
    dir_tab.push_back(row_req(FuncTick, '0, 10'd511));
    dir_tab.push_back(row_req(FuncTick, '0, 10'd461));
    dir_tab.push_back(row_req(FuncTick, '0, 10'd563));
    // one tiny period saturates the speed, then the integral runs to its floor
    dir_tab.push_back(row_wr(RegRefSpeed, 16'd0));
    dir_tab.push_back(row_wr(RegGainP, 16'hFFFF));
    dir_tab.push_back(row_wr(RegGainI, 16'hFFFF));
    dir_tab.push_back(row_wr(RegStepTime, 16'hFFFF));
    dir_tab.push_back(row_wr(RegMinPeriod, 16'd0));
    dir_tab.push_back(row_wr(RegMaxPeriod, 16'hFFFF));
    dir_tab.push_back(row_req(FuncEdge, 16'd1, '0));
    repeat (9) dir_tab.push_back(row_known(FuncTick, '0, 10'd0, 8'd0, 12'd4095));
    // unused indexes must leave everything alone
    dir_tab.push_back(row_wr(RegSpareA, 16'h1234));
    dir_tab.push_back(row_wr(RegSpareB, 16'hFFFF));
    dir_tab.push_back(row_wr(RegRefSpeed, 16'd255));
    dir_tab.push_back(row_req(FuncTick, '0, 10'd1023));
    // crossed limits keep nothing
    dir_tab.push_back(row_wr(RegMinPeriod, 16'd500));
    dir_tab.push_back(row_wr(RegMaxPeriod, 16'd400));
    dir_tab.push_back(row_req(FuncEdge, 16'd450, '0));
    dir_tab.push_back(row_req(FuncEdge, 16'd1000, '0));
    dir_tab.push_back(row_req(FuncTick, '0, 10'd512));
    dir_tab.push_back(row_wr(RegGainP, 16'd0));
    dir_tab.push_back(row_wr(RegGainI, 16'd0));
    dir_tab.push_back(row_wr(RegStepTime, 16'd0));
    dir_tab.push_back(row_known(FuncTick, '0, 10'd512, 8'd0, 12'd4095));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        if (!prev_wr) drain_all();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        cfg_valid_i <= 1'b0;
        send_req(dir_tab[i].kind, dir_tab[i].per, dir_tab[i].trim, dir_tab[i].known,
                 dir_tab[i].duty, dir_tab[i].speed);
      end
      prev_wr = dir_tab[i].wr;
    end

    // long run of ticks at low speed drives the integral to its ceiling
    run_phase(400, 0, 0, 1'b1);
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: run_phase(95, 0, 0, 1'b0);
        1: run_phase(95, 70, 0, 1'b0);
        2: run_phase(95, 0, 70, 1'b0);
        default: run_phase(95, 26, 26, 1'b0);
      endcase
    end

    drain_all();
    repeat (80) @(posedge clk_i);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
